// ===== rtl/sfcc_pkg.sv =====
package sfcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int TEMP_W     = 12;
    localparam int HUMI_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 3;
    localparam int WORD_W     = 16;
    localparam int PROD_W     = 27;
    localparam int QUOT_W     = 11;

    localparam logic [BYTE_W-1:0]  CRC_POLY   = 8'h31;
    localparam logic [BYTE_W-1:0]  CRC_INIT   = 8'hFF;
    localparam logic [10:0]        TEMP_SPAN  = 11'd1750;
    localparam logic [9:0]         HUMI_SPAN  = 10'd1000;
    localparam logic [WORD_W:0]    FULL_SCALE = 17'd65535;
    localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 12'd450;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TBAD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HBAD = 2'd2;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    // CRC-8, poly 0x31, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // x / 65535 for x < 2^27: x = q0*65536 + lo, so the remainder of q0*65535
    // is lo + q0, which stays below twice the divisor.
    function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q0;
        logic [WORD_W:0]   rem;
        q0  = x[PROD_W-1:WORD_W];
        rem = {1'b0, x[WORD_W-1:0]} + {{(WORD_W+1-QUOT_W){1'b0}}, q0};
        return (rem >= FULL_SCALE) ? q0 + 1'b1 : q0;
    endfunction

endpackage

// ===== rtl/sfcc_rx_if.sv =====
interface sfcc_rx_if
    import sfcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/sfcc_result_if.sv =====
interface sfcc_result_if
    import sfcc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [TEMP_W-1:0]   temperature_tenths;
    logic [HUMI_W-1:0]          humidity_tenths;
    logic [STATUS_W-1:0]        frame_status;

    modport source (output valid, output temperature_tenths, output humidity_tenths,
                    output frame_status, input ready);
    modport sink   (input valid, input temperature_tenths, input humidity_tenths,
                    input frame_status, output ready);
endinterface

// ===== rtl/sensor_frame_crc_check_convert.sv =====
// Decodes a six-byte temperature/humidity frame (temperature word, its CRC-8,
// humidity word, its CRC-8; words big-endian, CRC-8 poly 0x31 from 0xFF per
// word). One byte request is taken every cycle unless a stalled output holds a
// full capture register. After the sixth byte the frame passes the capture
// register and the scaling register, then one result request follows, carrying
// temperature in 0.1 degree units (1750*raw/65535 - 450), humidity in 0.1 percent
// units (1000*raw/65535) and a status: 0 ok, 1 temperature CRC bad (wins when both
// are bad), 2 humidity CRC bad; on a bad CRC both values read 0. frame_start
// restarts the byte count; after byte six the count wraps, so consecutive frames
// need no start flag. A stalled output holds the output and a full capture stage.
module sensor_frame_crc_check_convert
    import sfcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfcc_rx_if.sink       rx,
    sfcc_result_if.source result
);

    logic [POS_W-1:0]  pos;
    logic              rx_fire;
    logic              s1_advance;

    logic [POS_W-1:0]  byte_position_reg;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] high_byte_reg;
    logic [WORD_W-1:0] temp_raw_reg;
    logic [WORD_W-1:0] humi_raw_reg;
    logic              temp_ok_reg;

    logic                s1_valid_reg;
    logic [WORD_W-1:0]   s1_temp_reg;
    logic [WORD_W-1:0]   s1_humi_reg;
    logic [STATUS_W-1:0] s1_status_reg;

    logic                       out_valid_reg;
    logic signed [TEMP_W-1:0]   out_temp_reg;
    logic [HUMI_W-1:0]          out_humi_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    logic [BYTE_W-1:0]   crc_fed;
    logic [PROD_W-1:0]   temp_prod;
    logic [PROD_W-1:0]   humi_prod;
    logic [QUOT_W-1:0]   temp_q;
    logic [QUOT_W-1:0]   humi_q;
    logic [TEMP_W-1:0]   temp_next;
    logic [HUMI_W-1:0]   humi_next;

    assign s1_advance = !out_valid_reg || result.ready;
    assign rx.ready   = !s1_valid_reg || s1_advance;
    assign rx_fire    = rx.valid && rx.ready;

    always_comb
    begin
        pos = byte_position_reg;
        if (rx.frame_start || pos > POS_H_CRC)
            pos = POS_T_HI;
    end

    // high bytes restart the CRC from its init value
    assign crc_fed = crc8_feed((pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : crc_reg,
                               rx.rx_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= POS_T_HI;
            crc_reg           <= CRC_INIT;
            high_byte_reg     <= '0;
            temp_raw_reg      <= '0;
            humi_raw_reg      <= '0;
            temp_ok_reg       <= 1'b0;
        end
        else if (rx_fire)
        begin
            byte_position_reg <= (pos == POS_H_CRC) ? POS_T_HI : pos + 1'b1;
            case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc_reg       <= crc_fed;
                    high_byte_reg <= rx.rx_byte;
                end
                POS_T_LO:
                begin
                    crc_reg      <= crc_fed;
                    temp_raw_reg <= {high_byte_reg, rx.rx_byte};
                end
                POS_H_LO:
                begin
                    crc_reg      <= crc_fed;
                    humi_raw_reg <= {high_byte_reg, rx.rx_byte};
                end
                POS_T_CRC:
                    temp_ok_reg <= (crc_reg == rx.rx_byte);
                default:
                begin
                end
            endcase
        end
    end

    // capture stage: raw words and status of a complete frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx_fire && (pos == POS_H_CRC);
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && pos == POS_H_CRC)
        begin
            s1_temp_reg <= temp_raw_reg;
            s1_humi_reg <= humi_raw_reg;
            if (!temp_ok_reg)
                s1_status_reg <= STATUS_TBAD;
            else if (crc_reg != rx.rx_byte)
                s1_status_reg <= STATUS_HBAD;
            else
                s1_status_reg <= STATUS_OK;
        end
    end

    // scaling: constant multiply, then divide by 65535 with one correction
    assign temp_prod = PROD_W'({5'd0, s1_temp_reg} * {16'd0, TEMP_SPAN});
    assign humi_prod = PROD_W'({4'd0, s1_humi_reg} * {17'd0, HUMI_SPAN});
    assign temp_q    = div_full_scale(temp_prod);
    assign humi_q    = div_full_scale(humi_prod);
    assign temp_next = {{(TEMP_W-QUOT_W){1'b0}}, temp_q} - TEMP_OFFSET;
    assign humi_next = humi_q[HUMI_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            if (s1_status_reg == STATUS_OK)
            begin
                out_temp_reg <= temp_next;
                out_humi_reg <= humi_next;
            end
            else
            begin
                out_temp_reg <= '0;
                out_humi_reg <= '0;
            end
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.temperature_tenths = out_temp_reg;
    assign result.humidity_tenths    = out_humi_reg;
    assign result.frame_status       = out_status_reg;

endmodule
